>>> src/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: item structs,
// character codes and fixed cell values.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;
   localparam int CELL_W          = 16;

   localparam logic       KIND_PUT  = 1'b0;
   localparam logic       KIND_READ = 1'b1;

   localparam logic [7:0] CHAR_BACKSPACE  = 8'h08;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_CLEAR      = 8'h0B;
   localparam logic [7:0] CHAR_BLANK      = 8'h20;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

   localparam logic [7:0] ATTR_RESET = 8'h07;

   // prompt cells: '$' in red-ish attr, ':' in white attr, bare space
   localparam logic [CELL_W-1:0] CELL_PROMPT_DOLLAR = 16'h0C24;
   localparam logic [CELL_W-1:0] CELL_PROMPT_COLON  = 16'h0F3A;
   localparam logic [CELL_W-1:0] CELL_PROMPT_SPACE  = 16'h0020;

   typedef struct packed {
      logic        kind;
      logic [7:0]  char_code;
      logic        first_of_string;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_value;
      logic [6:0]  cursor_column;
      logic [4:0]  cursor_row;
   } rsp_type;

endpackage
`default_nettype wire

>>> src/text_console_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Character terminal over a ROWS x COLUMNS store of 16-bit cells
// (attribute in the high byte, character in the low byte).
//
//   channel   ports                               direction  transfer when
//   request   start, busy, req_item               in         start && !busy
//   response  rsp_strobe, rsp_item                out        rsp_strobe (1 cycle)
//   csr       csr_write_enable, csr_write_data    in         csr_write_enable
//
// A read past the end of the store is answered straight from idle; every
// other item keeps busy high until it is done. A backspace not at column 0
// writes a blank, then an underscore; the prompt tab writes the three
// prompt cells in turn. The response appears the cycle after the item's
// last cycle.
// Clear walks the store once. A put that runs off the last row scrolls
// through the one read port and one write port of the cell RAM; each write
// lands in the cycle after its read.
// Reset: synchronous; afterwards busy stays high while every cell is
// written to zero.
// The receiver cannot stall: each response is held for exactly one cycle.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire tcw_pkg::req_type req_item,
   output logic                  rsp_strobe,
   output tcw_pkg::rsp_type      rsp_item,
   input  wire logic             csr_write_enable,
   input  wire logic [7:0]       csr_write_data
);
   import tcw_pkg::*;

   localparam int CellCount = ROWS * COLUMNS;
   localparam int AW        = $clog2(CellCount);

   // attribute byte for ordinary characters, blanks and underscores
   logic [7:0] attr_ff, attr_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;
   logic [CELL_W-1:0] rd_data;

   assign attr_in = csr_write_enable ? csr_write_data : attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   // sequencer: cursor, per-character writes, clear and scroll sweeps
   tcw_seq #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .AW      (AW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .attr       (attr_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   // cell store, registered read data
   tcw_ram #(
      .DEPTH (CellCount),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire

>>> src/tcw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [tcw_pkg::CELL_W-1:0] wr_data,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [tcw_pkg::CELL_W-1:0] rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> src/tcw_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_seq
// Item sequencer: cursor state, cell writes for puts and control characters,
// clear and scroll sweeps over the cell store, registered result.
// ----------------------------------------------------------------------------
module tcw_seq #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int AW      = 11
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire tcw_pkg::req_type           req_item,
   output logic                            rsp_strobe,
   output tcw_pkg::rsp_type                rsp_item,
   input  wire logic [7:0]                 attr,
   output logic                            wr_en,
   output logic      [AW-1:0]              wr_addr,
   output logic      [tcw_pkg::CELL_W-1:0] wr_data,
   output logic      [AW-1:0]              rd_addr,
   input  wire logic [tcw_pkg::CELL_W-1:0] rd_data
);
   import tcw_pkg::*;

   localparam int CellCount = ROWS * COLUMNS;
   localparam int CW        = $clog2(COLUMNS);
   localparam int RW        = $clog2(ROWS);
   localparam logic [AW-1:0] LastAddr    = AW'(CellCount - 1);
   localparam logic [AW-1:0] LastRowBase = AW'(CellCount - COLUMNS);
   localparam logic [CW-1:0] LastCol     = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] LastRow     = RW'(ROWS - 1);

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_READ, S_PUT, S_CLEAR, S_SCROLL
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [AW-1:0]     base_ff, base_in;      // row_ff * COLUMNS
   logic [1:0]        step_ff, step_in;
   logic [AW-1:0]     scan_ff, scan_in;
   logic              scan_done_ff, scan_done_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   logic              pend_blank_ff, pend_blank_in;
   req_type           item_ff, item_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_item_ff, rsp_item_in;

   logic [AW-1:0]     cur_addr;
   logic              put_wr;
   logic [AW-1:0]     put_addr;
   logic [CELL_W-1:0] put_data;
   logic              put_last;
   logic [CW-1:0]     put_col;
   logic              put_adv;
   logic              blank_now;

   function automatic rsp_type make_rsp(logic [CELL_W-1:0] v, logic [CW-1:0] c,
                                        logic [RW-1:0] r);
      rsp_type t;
      t.cell_value    = v;
      t.cursor_column = 7'(c);
      t.cursor_row    = 5'(r);
      return t;
   endfunction

   assign cur_addr = AW'(base_ff + AW'(col_ff));

   // what one put step writes and where the cursor goes
   always_comb begin
      put_wr   = 1'b1;
      put_addr = cur_addr;
      put_data = {attr, item_ff.char_code};
      put_last = 1'b1;
      put_col  = col_ff;
      put_adv  = 1'b0;
      unique case (item_ff.char_code)
         CHAR_BACKSPACE: begin
            if (step_ff == 2'd0) begin
               put_data = {attr, CHAR_BLANK};
               put_last = (col_ff == '0);
            end else begin
               put_addr = AW'(cur_addr - AW'(1));
               put_data = {attr, CHAR_UNDERSCORE};
               put_col  = CW'(col_ff - CW'(1));
            end
         end
         CHAR_NEWLINE: begin
            put_data = {attr, CHAR_BLANK};
            put_col  = '0;
            put_adv  = 1'b1;
         end
         CHAR_TAB: begin
            if (item_ff.first_of_string) begin
               put_addr = AW'(base_ff + AW'(step_ff));
               put_last = (step_ff == 2'd2);
               put_col  = (col_ff < CW'(3)) ? CW'(3) : col_ff;
               unique case (step_ff)
                  2'd0:    put_data = CELL_PROMPT_DOLLAR;
                  2'd1:    put_data = CELL_PROMPT_COLON;
                  default: put_data = CELL_PROMPT_SPACE;
               endcase
            end else begin
               put_data = {attr, CHAR_UNDERSCORE};
            end
         end
         CHAR_CLEAR: begin
            put_wr = 1'b0;
         end
         default: begin
            if (col_ff == LastCol) begin
               put_col = '0;
               put_adv = 1'b1;
            end else begin
               put_col = CW'(col_ff + CW'(1));
            end
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      base_in       = base_ff;
      step_in       = step_ff;
      scan_in       = scan_ff;
      scan_done_in  = scan_done_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      pend_blank_in = pend_blank_ff;
      item_in       = item_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_addr       = '0;
      blank_now     = 1'b0;
      unique case (state_ff)
         S_INIT, S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff;
            scan_in = AW'(scan_ff + AW'(1));
            if (scan_ff == LastAddr) begin
               state_in = S_IDLE;
               if (state_ff == S_CLEAR) begin
                  rsp_strobe_in = 1'b1;
                  rsp_item_in   = make_rsp('0, col_ff, row_ff);
               end
            end
         end
         S_IDLE: begin
            if (start) begin
               item_in = req_item;
               step_in = '0;
               if (req_item.kind == KIND_READ) begin
                  if (32'(req_item.cell_index) < CellCount) begin
                     rd_addr  = AW'(req_item.cell_index);
                     state_in = S_READ;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     rsp_item_in   = make_rsp('0, col_ff, row_ff);
                  end
               end else begin
                  state_in = S_PUT;
               end
            end
         end
         S_READ: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_item_in   = make_rsp(rd_data, col_ff, row_ff);
         end
         S_PUT: begin
            if (item_ff.char_code == CHAR_CLEAR) begin
               state_in = S_CLEAR;
               scan_in  = '0;
               col_in   = '0;
               row_in   = '0;
               base_in  = '0;
            end else begin
               wr_en   = put_wr;
               wr_addr = put_addr;
               wr_data = put_data;
               if (!put_last) begin
                  step_in = 2'(step_ff + 2'd1);
               end else if (put_adv && row_ff == LastRow) begin
                  // past the last row: scroll, cursor lands on last row start
                  state_in     = S_SCROLL;
                  col_in       = '0;
                  scan_in      = '0;
                  scan_done_in = 1'b0;
               end else begin
                  state_in      = S_IDLE;
                  col_in        = put_col;
                  rsp_strobe_in = 1'b1;
                  if (put_adv) begin
                     row_in      = RW'(row_ff + RW'(1));
                     base_in     = AW'(base_ff + AW'(COLUMNS));
                     rsp_item_in = make_rsp('0, put_col, RW'(row_ff + RW'(1)));
                  end else begin
                     rsp_item_in = make_rsp('0, put_col, row_ff);
                  end
               end
            end
         end
         S_SCROLL: begin
            // read cell i+COLUMNS, write it to cell i in the next cycle; last-row cells get blanks
            if (!scan_done_ff) begin
               blank_now     = (scan_ff >= LastRowBase);
               rd_addr       = blank_now ? '0 : AW'(scan_ff + AW'(COLUMNS));
               pend_in       = 1'b1;
               pend_addr_in  = scan_ff;
               pend_blank_in = blank_now;
               scan_in       = AW'(scan_ff + AW'(1));
               scan_done_in  = (scan_ff == LastAddr);
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_addr_ff;
               wr_data = pend_blank_ff ? {attr, CHAR_BLANK} : rd_data;
               if (pend_addr_ff == LastAddr) begin
                  state_in      = S_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_item_in   = make_rsp('0, col_ff, row_ff);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         col_ff        <= '0;
         row_ff        <= '0;
         base_ff       <= '0;
         step_ff       <= '0;
         scan_ff       <= '0;
         scan_done_ff  <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         base_ff       <= base_in;
         step_ff       <= step_in;
         scan_ff       <= scan_in;
         scan_done_ff  <= scan_done_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      pend_addr_ff  <= pend_addr_in;
      pend_blank_ff <= pend_blank_in;
      item_ff       <= item_in;
      rsp_item_ff   <= rsp_item_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule
`default_nettype wire
